// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, muted while reset is asserted.
`define MVC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define MVC_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`else

`define MVC_ASSERT(label, clk, rst_n, prop)
`define MVC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hdl/mvc_pkg.sv =====
package mvc_pkg;

	// controller states
	localparam logic [2:0] ST_SETUP  = 3'd0;
	localparam logic [2:0] ST_WAIT   = 3'd1;
	localparam logic [2:0] ST_SETTLE = 3'd2;
	localparam logic [2:0] ST_VERIFY = 3'd3;
	localparam logic [2:0] ST_SIGNAL = 3'd4;
	localparam logic [2:0] ST_PAUSE  = 3'd5;
	localparam logic [2:0] ST_PDOWN  = 3'd6;

	// request kinds
	localparam logic [1:0] REQ_STEP = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_PDN  = 2'd2;
	localparam logic [1:0] REQ_PUP  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd2;

	localparam logic [CFG_W-1:0] SETTLE_RST = 16'd100;
	localparam logic [CFG_W-1:0] VERIFY_RST = 16'd1000;
	localparam logic [CFG_W-1:0] PAUSE_RST  = 16'd5000;

	typedef struct packed {
		logic [2:0] state;
		logic       running;
		logic       pdn_pend;
		logic       pup_pend;
	} ctl_t;

	typedef struct packed {
		logic [CFG_W-1:0] settle;
		logic [CFG_W-1:0] verify;
		logic [CFG_W-1:0] pause;
	} limits_t;

	typedef struct packed {
		logic [2:0] fsm_state;
		logic       detect_pulse;
		logic       sensor_configure;
		logic       sensor_power_down;
		logic       sensor_power_up;
	} res_t;

endpackage

// ===== hdl/mvc_req_if.sv =====
interface mvc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       motion;

	modport source(output valid, output req_type, output motion, input ready);
	modport sink(input valid, input req_type, input motion, output ready);
endinterface

// ===== hdl/mvc_rsp_if.sv =====
interface mvc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] fsm_state;
	logic       detect_pulse;
	logic       sensor_configure;
	logic       sensor_power_down;
	logic       sensor_power_up;

	modport source(output valid, output fsm_state, output detect_pulse,
		output sensor_configure, output sensor_power_down, output sensor_power_up,
		input ready);
	modport sink(input valid, input fsm_state, input detect_pulse,
		input sensor_configure, input sensor_power_down, input sensor_power_up,
		output ready);
endinterface

// ===== hdl/motion_verify_controller_unit.sv =====
// Motion verify controller.
// req (sink): one beat per event: task step with the motion bit, millisecond
//   tick, power-down request or power-up request.
// rsp (source): exactly one beat per request beat, in order, carrying the
//   state after the event and the one-shot action bits (detect pulse,
//   sensor configure, sensor power down, sensor power up).
// wr_en/wr_index/wr_data: limit registers (settle, verify window, pause), which the user
//   must write only while the block is idle; the block itself does not enforce this. Unused indexes are dropped.
// A request beat accepted on req lands in the input register, is evaluated
//   and its result registered in the result register, and is offered on
//   rsp from then on. Throughput: one beat per cycle while rsp is not held
//   off, set by the single state update plus timer compare between the two registers.
// Stall: while rsp is held off the result stays put, one more beat can
//   sit in the input register, and req.ready drops when both are full.
// Reset: state goes to setup, timer cleared and stopped, request flags
//   cleared, limits back to 100 / 1000 / 5000 ms, both stages empty.
`include "assert_macros.svh"

module motion_verify_controller_unit #(
	parameter int TIMER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mvc_req_if.sink                            req,
	mvc_rsp_if.source                          rsp,
	input  logic                               wr_en,
	input  logic [mvc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [mvc_pkg::CFG_W-1:0]          wr_data
);

	// configuration
	mvc_pkg::limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.settle <= mvc_pkg::SETTLE_RST;
			limits_q.verify <= mvc_pkg::VERIFY_RST;
			limits_q.pause  <= mvc_pkg::PAUSE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				mvc_pkg::CFG_SETTLE: limits_q.settle <= wr_data;
				mvc_pkg::CFG_VERIFY: limits_q.verify <= wr_data;
				mvc_pkg::CFG_PAUSE:  limits_q.pause  <= wr_data;
				default: ;
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic       motion_s1;

	// result stage
	logic          valid_s2;
	mvc_pkg::res_t res_s2;

	logic s2_free;
	logic adv;

	assign s2_free   = !valid_s2 || rsp.ready;
	assign adv       = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload of the input stage: load on every accepted beat
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			motion_s1   <= req.motion;
		end
	end

	// controller state, updated as each beat moves to the result stage
	mvc_pkg::ctl_t         ctl_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	mvc_pkg::ctl_t         ctl_nxt;
	logic [TIMER_BITS-1:0] elapsed_nxt;
	mvc_pkg::res_t         res_nxt;

	mvc_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.req_type    (req_type_s1),
		.motion      (motion_s1),
		.ctl         (ctl_q),
		.elapsed     (elapsed_q),
		.limits      (limits_q),
		.ctl_nxt     (ctl_nxt),
		.elapsed_nxt (elapsed_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.state    <= mvc_pkg::ST_SETUP;
			ctl_q.running  <= 1'b0;
			ctl_q.pdn_pend <= 1'b0;
			ctl_q.pup_pend <= 1'b0;
			elapsed_q      <= '0;
		end else if (adv) begin
			ctl_q     <= ctl_nxt;
			elapsed_q <= elapsed_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign rsp.valid             = valid_s2;
	assign rsp.fsm_state         = res_s2.fsm_state;
	assign rsp.detect_pulse      = res_s2.detect_pulse;
	assign rsp.sensor_configure  = res_s2.sensor_configure;
	assign rsp.sensor_power_down = res_s2.sensor_power_down;
	assign rsp.sensor_power_up   = res_s2.sensor_power_up;

	// a detection always leads into the pause hold-off
	`MVC_ASSERT(a_pulse_pause, clk, arst_n, (valid_s2 && res_s2.detect_pulse) |-> (res_s2.fsm_state == mvc_pkg::ST_PAUSE))

	// power up always lands in wait
	`MVC_ASSERT(a_pup_wait, clk, arst_n, (valid_s2 && res_s2.sensor_power_up) |-> (res_s2.fsm_state == mvc_pkg::ST_WAIT))

	// a beat handed to the result stage is offered in the next cycle
	`MVC_ASSERT(a_adv_out, clk, arst_n, adv |=> valid_s2)

	// an unused state code is never reached
	`MVC_ASSERT_ALWAYS(a_no_bad_state, clk, ctl_q.state <= mvc_pkg::ST_PDOWN)

endmodule

// ===== hdl/mvc_step.sv =====
module mvc_step #(
	parameter int TIMER_BITS = 16
) (
	input  logic [1:0]            req_type,
	input  logic                  motion,
	input  mvc_pkg::ctl_t         ctl,
	input  logic [TIMER_BITS-1:0] elapsed,
	input  mvc_pkg::limits_t      limits,
	output mvc_pkg::ctl_t         ctl_nxt,
	output logic [TIMER_BITS-1:0] elapsed_nxt,
	output mvc_pkg::res_t         res
);

	localparam int CMP_W = (TIMER_BITS > mvc_pkg::CFG_W) ? TIMER_BITS : mvc_pkg::CFG_W;

	logic [CMP_W-1:0] el_w;
	logic             settle_up;
	logic             verify_up;
	logic             pause_up;

	assign el_w      = CMP_W'(elapsed);
	assign settle_up = el_w >= CMP_W'(limits.settle);
	assign verify_up = el_w >= CMP_W'(limits.verify);
	assign pause_up  = el_w >= CMP_W'(limits.pause);

	always_comb begin
		ctl_nxt     = ctl;
		elapsed_nxt = elapsed;
		res         = '0;

		case (req_type)
			mvc_pkg::REQ_TICK: begin
				// saturate at all ones
				if (ctl.running && (elapsed != {TIMER_BITS{1'b1}}))
					elapsed_nxt = elapsed + TIMER_BITS'(1);
			end
			mvc_pkg::REQ_PDN: ctl_nxt.pdn_pend = 1'b1;
			mvc_pkg::REQ_PUP: ctl_nxt.pup_pend = 1'b1;
			default: begin
				unique case (ctl.state)
					mvc_pkg::ST_WAIT: begin
						if (ctl.pdn_pend) begin
							ctl_nxt.state = mvc_pkg::ST_PDOWN;
						end else if (motion) begin
							ctl_nxt.state   = mvc_pkg::ST_SETTLE;
							ctl_nxt.running = 1'b1;
							elapsed_nxt     = '0;
						end
					end
					mvc_pkg::ST_SETTLE: begin
						if (settle_up) begin
							ctl_nxt.state   = mvc_pkg::ST_VERIFY;
							ctl_nxt.running = 1'b1;
							elapsed_nxt     = '0;
						end
					end
					mvc_pkg::ST_VERIFY: begin
						// window expiry takes priority over motion
						if (verify_up) begin
							ctl_nxt.state   = mvc_pkg::ST_WAIT;
							ctl_nxt.running = 1'b0;
						end else if (motion) begin
							ctl_nxt.state   = mvc_pkg::ST_SIGNAL;
							ctl_nxt.running = 1'b0;
						end
					end
					mvc_pkg::ST_SIGNAL: begin
						res.detect_pulse = 1'b1;
						ctl_nxt.state    = mvc_pkg::ST_PAUSE;
						ctl_nxt.running  = 1'b1;
						elapsed_nxt      = '0;
					end
					mvc_pkg::ST_PAUSE: begin
						if (pause_up)
							ctl_nxt.state = mvc_pkg::ST_WAIT;
					end
					mvc_pkg::ST_PDOWN: begin
						if (ctl.pdn_pend) begin
							ctl_nxt.pdn_pend      = 1'b0;
							res.sensor_power_down = 1'b1;
						end
						if (ctl.pup_pend) begin
							ctl_nxt.pup_pend    = 1'b0;
							res.sensor_power_up = 1'b1;
							ctl_nxt.state       = mvc_pkg::ST_WAIT;
						end
					end
					default: begin
						// setup, and the unused code, configure the sensor
						res.sensor_configure = 1'b1;
						ctl_nxt.state        = mvc_pkg::ST_WAIT;
					end
				endcase
			end
		endcase

		res.fsm_state = ctl_nxt.state;
	end

endmodule
